// ===== hdl/torsion_one_four_distance_assert.svh =====
// Assertion macros for the torsion 1-4 distance block.
// Used by hdl/torsion_one_four_distance.sv; needs i_clk and i_rst_n in scope.
`ifndef TORSION_ONE_FOUR_DISTANCE_ASSERT_SVH
`define TORSION_ONE_FOUR_DISTANCE_ASSERT_SVH

// same-cycle implication
`define TOFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TOFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tofd_pkg.sv =====
// Package for the torsion 1-4 distance block: widths, item types, register codes
// and the single-step square root and divide functions. No dependencies.
`default_nettype none

package tofd_pkg;

    localparam int COORD_WIDTH    = 20;
    localparam int TRIG_WIDTH     = 18;
    localparam int TRIG_FRAC_BITS = 16;
    localparam int DIST_WIDTH     = 22;
    localparam int CFG_IDX_W      = 2;

    localparam int DIFF_W     = COORD_WIDTH + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int LEN_W      = DIFF_W;
    localparam int DIV_N_W    = PROD_W + 1;
    localparam int DIV_Q_W    = COORD_WIDTH + 4;
    localparam int DIV_R_W    = LEN_W + 1;
    localparam int Z_W        = DIV_Q_W + 1;
    localparam int ZSQ_W      = 2 * DIV_Q_W;
    localparam int RADC_W     = ZSQ_W + 1;
    localparam int RAD_W      = PROD_W;
    localparam int PERP_W     = DIFF_W;
    localparam int TPROD_W    = PERP_W + 1 + TRIG_WIDTH;
    localparam int TRIG_OUT_W = TPROD_W - TRIG_FRAC_BITS;
    localparam int TRIG_HALF  = 2 ** (TRIG_FRAC_BITS - 1);
    localparam int E_W        = Z_W + 1;
    localparam int SQ_RAD_W   = 2 * E_W;
    localparam int SQ_STEPS   = SQ_RAD_W / 2;
    localparam int SQ_ROOT_W  = SQ_STEPS;
    localparam int SQ_REM_W   = SQ_ROOT_W + 3;

    localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

    // 55 degrees in Q16
    localparam logic signed [TRIG_WIDTH-1:0] COS_RESET = 18'sd37590;
    localparam logic signed [TRIG_WIDTH-1:0] SIN_RESET = 18'sd53684;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_THETA = 2'd0,
        REG_SIN_THETA = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] first_z;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
        logic signed [COORD_WIDTH-1:0] second_z;
        logic signed [COORD_WIDTH-1:0] third_x;
        logic signed [COORD_WIDTH-1:0] third_y;
        logic signed [COORD_WIDTH-1:0] third_z;
        logic signed [COORD_WIDTH-1:0] fourth_x;
        logic signed [COORD_WIDTH-1:0] fourth_y;
        logic signed [COORD_WIDTH-1:0] fourth_z;
    } t_in_item;

    typedef struct packed {
        logic [DIST_WIDTH-1:0] distance;
        logic                  degenerate_axis;
    } t_out_item;

    typedef struct packed {
        logic [SQ_RAD_W-1:0]  rad;
        logic [SQ_ROOT_W-1:0] root;
        logic [SQ_REM_W-1:0]  rem;
    } t_sq;

    typedef struct packed {
        logic [DIV_Q_W-1:0] low;
        logic [DIV_R_W-1:0] rem;
        logic [DIV_Q_W-1:0] quo;
    } t_dv;

    function automatic t_sq sq_start(input logic [SQ_RAD_W-1:0] rad);
        t_sq s;
        s.rad  = rad;
        s.root = '0;
        s.rem  = '0;
        return s;
    endfunction

    // one result bit of a restoring square root
    function automatic t_sq sq_step(input t_sq s);
        logic [SQ_REM_W-1:0] cur;
        logic [SQ_REM_W-1:0] trial;
        t_sq n;
        cur   = {s.rem[SQ_REM_W-3:0], s.rad[SQ_RAD_W-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        n.rad = {s.rad[SQ_RAD_W-3:0], 2'b00};
        if (cur >= trial) begin
            n.rem  = cur - trial;
            n.root = {s.root[SQ_ROOT_W-2:0], 1'b1};
        end else begin
            n.rem  = cur;
            n.root = {s.root[SQ_ROOT_W-2:0], 1'b0};
        end
        return n;
    endfunction

    // quotient is known to fit DIV_Q_W bits, so the top part starts below the divisor
    function automatic t_dv dv_start(input logic [DIV_N_W-1:0] num);
        t_dv s;
        s.low = num[DIV_Q_W-1:0];
        s.rem = DIV_R_W'(num[DIV_N_W-1:DIV_Q_W]);
        s.quo = '0;
        return s;
    endfunction

    function automatic t_dv dv_step(input t_dv s, input logic [LEN_W-1:0] d);
        logic [DIV_R_W-1:0] cur;
        t_dv n;
        cur   = {s.rem[DIV_R_W-2:0], s.low[DIV_Q_W-1]};
        n.low = {s.low[DIV_Q_W-2:0], 1'b0};
        if (cur >= {1'b0, d}) begin
            n.rem = cur - {1'b0, d};
            n.quo = {s.quo[DIV_Q_W-2:0], 1'b1};
        end else begin
            n.rem = cur;
            n.quo = {s.quo[DIV_Q_W-2:0], 1'b0};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/torsion_one_four_distance.sv =====
// Torsion 1-4 distance: top level, a fully pipelined datapath.
// Depends on tofd_pkg and torsion_one_four_distance_assert.svh.
//
//  channel  direction  handshake                payload
//  in       input      i_in_valid / o_in_stall  i_in_item  (t_in_item)
//  out      output     o_out_valid / i_out_stall o_out_item (t_out_item)
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; the path holds three 26-step square
// root sections (the middle one two roots wide) and two 24-step dividers, one step per stage.
// Reset clears all valid bits and loads the 55 degree cosine and sine.
// A stalled result freezes every stage and stalls the input; nothing is lost.
`default_nettype none

module torsion_one_four_distance (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  tofd_pkg::t_in_item                       i_in_item,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output tofd_pkg::t_out_item                      o_out_item,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [tofd_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [tofd_pkg::TRIG_WIDTH-1:0]          i_cfg_data
);
    import tofd_pkg::*;

    localparam int T = 3 + SQ_STEPS + 1 + DIV_Q_W + 2 + SQ_STEPS + 4 + SQ_STEPS + 1;

    typedef struct packed {
        logic signed [DOT_W-1:0] na;
        logic signed [DOT_W-1:0] nb;
        logic signed [DOT_W-1:0] da;
        logic signed [DOT_W-1:0] db;
    } t_l_side;

    typedef struct packed {
        logic signed [DOT_W-1:0] na;
        logic signed [DOT_W-1:0] nb;
        logic                    neg1;
        logic                    neg4;
        logic [LEN_W-1:0]        len;
        logic                    deg;
    } t_d_side;

    typedef struct packed {
        logic signed [E_W-1:0] dz;
        logic                  deg;
    } t_r_side;

    logic                          w_en;
    logic [T-1:0]                  r_vld;
    logic signed [TRIG_WIDTH-1:0]  r_cos_theta;
    logic signed [TRIG_WIDTH-1:0]  r_sin_theta;

    logic signed [COORD_WIDTH-1:0] w_p1 [3];
    logic signed [COORD_WIDTH-1:0] w_p2 [3];
    logic signed [COORD_WIDTH-1:0] w_p3 [3];
    logic signed [COORD_WIDTH-1:0] w_p4 [3];

    logic signed [DIFF_W-1:0] r_a [3];
    logic signed [DIFF_W-1:0] r_u [3];
    logic signed [DIFF_W-1:0] r_b [3];
    logic signed [PROD_W-1:0] r_uu [3];
    logic signed [PROD_W-1:0] r_aa [3];
    logic signed [PROD_W-1:0] r_bb [3];
    logic signed [PROD_W-1:0] r_au [3];
    logic signed [PROD_W-1:0] r_bu [3];
    logic signed [DOT_W-1:0]  r_nu, r_na, r_nb, r_da, r_db;

    t_sq     r_lsq   [SQ_STEPS];
    t_l_side r_lside [SQ_STEPS];

    logic [LEN_W-1:0]        w_len;
    t_l_side                 w_ls;
    logic signed [DOT_W-1:0] w_mag1, w_mag4;
    logic [DIV_N_W-1:0]      r_dn1, r_dn4;
    t_d_side                 r_ds0;

    t_dv     r_dv1 [DIV_Q_W];
    t_dv     r_dv4 [DIV_Q_W];
    t_d_side r_dvs [DIV_Q_W];

    logic [DIV_Q_W-1:0]      w_q1, w_q4;
    logic signed [Z_W-1:0]   r_z1, r_z4;
    logic [ZSQ_W-1:0]        r_zsq1, r_zsq4;
    logic signed [DOT_W-1:0] r_zna, r_znb;
    logic                    r_zdeg;

    logic signed [RADC_W-1:0] w_rc1, w_rc4;
    logic [RAD_W-1:0]         r_rad1, r_rad4;
    t_r_side                  r_rs0;

    t_sq     r_sq1 [SQ_STEPS];
    t_sq     r_sq4 [SQ_STEPS];
    t_r_side r_rs  [SQ_STEPS];

    logic [PERP_W-1:0]          w_r4;
    logic signed [TPROD_W-1:0]  r_pc, r_ps;
    logic [PERP_W-1:0]          r_x1;
    t_r_side                    r_ts;

    logic signed [TPROD_W-1:0]    w_cr, w_sr;
    logic signed [TRIG_OUT_W-1:0] w_c4, w_s4;
    logic signed [E_W-1:0]        r_e1, r_e2, r_e3;
    logic                         r_edeg;

    logic signed [SQ_RAD_W-1:0] r_q1, r_q2, r_q3;
    logic                       r_qdeg;
    logic [SQ_RAD_W-1:0]        r_sum;
    logic                       r_sdeg;

    t_sq  r_fsq  [SQ_STEPS];
    logic r_fdeg [SQ_STEPS];

    logic [SQ_ROOT_W-1:0] w_d;
    t_out_item            r_out;

    assign w_en        = !(r_vld[T-1] && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_vld[T-1];
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_theta <= COS_RESET;
            r_sin_theta <= SIN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COS_THETA: r_cos_theta <= i_cfg_data;
                REG_SIN_THETA: r_sin_theta <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[T-2:0], i_in_valid};
        end
    end

    always_comb begin
        w_p1 = '{i_in_item.first_x, i_in_item.first_y, i_in_item.first_z};
        w_p2 = '{i_in_item.second_x, i_in_item.second_y, i_in_item.second_z};
        w_p3 = '{i_in_item.third_x, i_in_item.third_y, i_in_item.third_z};
        w_p4 = '{i_in_item.fourth_x, i_in_item.fourth_y, i_in_item.fourth_z};
    end

    // differences, products, dot products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_a[k]  <= DIFF_W'(w_p1[k]) - DIFF_W'(w_p2[k]);
                r_u[k]  <= DIFF_W'(w_p3[k]) - DIFF_W'(w_p2[k]);
                r_b[k]  <= DIFF_W'(w_p4[k]) - DIFF_W'(w_p2[k]);
                r_uu[k] <= r_u[k] * r_u[k];
                r_aa[k] <= r_a[k] * r_a[k];
                r_bb[k] <= r_b[k] * r_b[k];
                r_au[k] <= r_a[k] * r_u[k];
                r_bu[k] <= r_b[k] * r_u[k];
            end
            r_nu <= DOT_W'(r_uu[0]) + DOT_W'(r_uu[1]) + DOT_W'(r_uu[2]);
            r_na <= DOT_W'(r_aa[0]) + DOT_W'(r_aa[1]) + DOT_W'(r_aa[2]);
            r_nb <= DOT_W'(r_bb[0]) + DOT_W'(r_bb[1]) + DOT_W'(r_bb[2]);
            r_da <= DOT_W'(r_au[0]) + DOT_W'(r_au[1]) + DOT_W'(r_au[2]);
            r_db <= DOT_W'(r_bu[0]) + DOT_W'(r_bu[1]) + DOT_W'(r_bu[2]);
        end
    end

    // bond length root
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lsq[0]   <= sq_step(sq_start(SQ_RAD_W'($unsigned(r_nu))));
            r_lside[0] <= '{na: r_na, nb: r_nb, da: r_da, db: r_db};
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_lsq[k]   <= sq_step(r_lsq[k-1]);
                r_lside[k] <= r_lside[k-1];
            end
        end
    end

    // rounded-division set-up: magnitude plus half the divisor
    assign w_len  = r_lsq[SQ_STEPS-1].root[LEN_W-1:0];
    assign w_ls   = r_lside[SQ_STEPS-1];
    assign w_mag1 = w_ls.da[DOT_W-1] ? -w_ls.da : w_ls.da;
    assign w_mag4 = w_ls.db[DOT_W-1] ? -w_ls.db : w_ls.db;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dn1 <= DIV_N_W'($unsigned(w_mag1)) + DIV_N_W'(w_len >> 1);
            r_dn4 <= DIV_N_W'($unsigned(w_mag4)) + DIV_N_W'(w_len >> 1);
            r_ds0 <= '{na: w_ls.na, nb: w_ls.nb, neg1: w_ls.da[DOT_W-1],
                       neg4: w_ls.db[DOT_W-1], len: w_len, deg: (w_len == '0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv1[0] <= dv_step(dv_start(r_dn1), r_ds0.len);
            r_dv4[0] <= dv_step(dv_start(r_dn4), r_ds0.len);
            r_dvs[0] <= r_ds0;
            for (int k = 1; k < DIV_Q_W; k++) begin
                r_dv1[k] <= dv_step(r_dv1[k-1], r_dvs[k-1].len);
                r_dv4[k] <= dv_step(r_dv4[k-1], r_dvs[k-1].len);
                r_dvs[k] <= r_dvs[k-1];
            end
        end
    end

    // axial parts and their squares, then perpendicular radicands
    assign w_q1  = r_dv1[DIV_Q_W-1].quo;
    assign w_q4  = r_dv4[DIV_Q_W-1].quo;
    assign w_rc1 = RADC_W'(r_zna) - $signed({1'b0, r_zsq1});
    assign w_rc4 = RADC_W'(r_znb) - $signed({1'b0, r_zsq4});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_z1   <= r_dvs[DIV_Q_W-1].neg1 ? -$signed(Z_W'(w_q1)) : $signed(Z_W'(w_q1));
            r_z4   <= r_dvs[DIV_Q_W-1].neg4 ? -$signed(Z_W'(w_q4)) : $signed(Z_W'(w_q4));
            r_zsq1 <= w_q1 * w_q1;
            r_zsq4 <= w_q4 * w_q4;
            r_zna  <= r_dvs[DIV_Q_W-1].na;
            r_znb  <= r_dvs[DIV_Q_W-1].nb;
            r_zdeg <= r_dvs[DIV_Q_W-1].deg;
            r_rad1 <= w_rc1[RADC_W-1] ? '0 : w_rc1[RAD_W-1:0];
            r_rad4 <= w_rc4[RADC_W-1] ? '0 : w_rc4[RAD_W-1:0];
            r_rs0  <= '{dz: E_W'(r_z1) - E_W'(r_z4), deg: r_zdeg};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq1[0] <= sq_step(sq_start(SQ_RAD_W'(r_rad1)));
            r_sq4[0] <= sq_step(sq_start(SQ_RAD_W'(r_rad4)));
            r_rs[0]  <= r_rs0;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_sq1[k] <= sq_step(r_sq1[k-1]);
                r_sq4[k] <= sq_step(r_sq4[k-1]);
                r_rs[k]  <= r_rs[k-1];
            end
        end
    end

    // rotation of the last atom, then the three components
    assign w_r4 = r_sq4[SQ_STEPS-1].root[PERP_W-1:0];
    assign w_cr = r_pc + TPROD_W'(TRIG_HALF);
    assign w_sr = r_ps + TPROD_W'(TRIG_HALF);
    assign w_c4 = w_cr[TPROD_W-1:TRIG_FRAC_BITS];
    assign w_s4 = w_sr[TPROD_W-1:TRIG_FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pc   <= $signed({1'b0, w_r4}) * r_cos_theta;
            r_ps   <= $signed({1'b0, w_r4}) * r_sin_theta;
            r_x1   <= r_sq1[SQ_STEPS-1].root[PERP_W-1:0];
            r_ts   <= r_rs[SQ_STEPS-1];
            r_e1   <= E_W'($signed({1'b0, r_x1})) - E_W'(w_c4);
            r_e2   <= E_W'(w_s4);
            r_e3   <= r_ts.dz;
            r_edeg <= r_ts.deg;
            r_q1   <= r_e1 * r_e1;
            r_q2   <= r_e2 * r_e2;
            r_q3   <= r_e3 * r_e3;
            r_qdeg <= r_edeg;
            r_sum  <= $unsigned(r_q1 + r_q2 + r_q3);
            r_sdeg <= r_qdeg;
        end
    end

    // components stay far inside +-(2^31-1), so no clamp is needed before squaring
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fsq[0]  <= sq_step(sq_start(r_sum));
            r_fdeg[0] <= r_sdeg;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_fsq[k]  <= sq_step(r_fsq[k-1]);
                r_fdeg[k] <= r_fdeg[k-1];
            end
        end
    end

    assign w_d = r_fsq[SQ_STEPS-1].root;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.degenerate_axis <= r_fdeg[SQ_STEPS-1];
            if (r_fdeg[SQ_STEPS-1]) begin
                r_out.distance <= '0;
            end else if (w_d > SQ_ROOT_W'(DIST_MAX)) begin
                r_out.distance <= DIST_MAX;
            end else begin
                r_out.distance <= w_d[DIST_WIDTH-1:0];
            end
        end
    end

`include "torsion_one_four_distance_assert.svh"

    `TOFD_ASSERT_NOW(a_deg_zero, o_out_valid && o_out_item.degenerate_axis,
        o_out_item.distance == '0, "degenerate axis with non-zero distance")
    `TOFD_ASSERT_NEXT(a_freeze, o_out_valid && i_out_stall,
        $stable(r_vld) && $stable(o_out_item), "pipeline moved while output stalled")
    `TOFD_ASSERT_NEXT(a_enter, i_in_valid && !o_in_stall,
        r_vld[0], "accepted item missing from first stage")

endmodule

`default_nettype wire
